// ===== hw/rtl/rds_pkg.sv =====
// Shared constants, widths and divider step types for the DDA ray setup core.
// No dependencies; every module of the block imports this package.
package rds_pkg;

  function automatic int max_int(int a, int b);
    return (a > b) ? a : b;
  endfunction

  localparam int FRAC_BITS = 16;
  localparam int MAP_BITS  = 8;

  localparam int COL_W  = 12;
  localparam int WID_W  = 12;
  localparam int POS_W  = MAP_BITS + FRAC_BITS;
  localparam int DIR_W  = FRAC_BITS + 2;
  localparam int RAY_W  = FRAC_BITS + 3;
  localparam int DIST_W = 32;

  // camera coordinate numerator: column * 2^(F+1), then cam = quotient - 2^F
  localparam int CAM_NUM_W = COL_W + FRAC_BITS + 1;
  localparam int CAM_W     = CAM_NUM_W + 1;

  // one shared restoring divider geometry for the camera and delta dividers
  localparam int DIV_NW   = max_int(CAM_NUM_W, 2 * FRAC_BITS + 1);
  localparam int DIV_DW   = max_int(WID_W, RAY_W);
  localparam int DELTA_QW = max_int(DIV_NW, DIST_W + 1);

  localparam int CFG_W     = max_int(POS_W, max_int(DIR_W, WID_W));
  localparam int CFG_IDX_W = 3;

  // register pipeline depth from the accepting edge to the result cycle
  localparam int LATENCY = 2 * DIV_NW + 7;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = CFG_IDX_W'(6);

  localparam logic [DIR_W-1:0] DIR_X_RST   = DIR_W'(1 << FRAC_BITS);
  localparam logic [DIR_W-1:0] PLANE_Y_RST = DIR_W'((66 * (1 << FRAC_BITS)) / 100);
  localparam logic [WID_W-1:0] WIDTH_RST   = WID_W'(640);

  localparam logic [CAM_W-1:0] CAM_ONE = CAM_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic              q;
    logic [DIV_DW-1:0] r;
  } div_step_t;

  typedef struct packed {
    logic [DIV_DW-1:0] rem;
    logic [DIV_NW-1:0] nq;   // numerator bits shift out at the top, quotient bits in at the bottom
  } div_stage_t;

  // one restoring division step: bring in one numerator bit, trial subtract
  function automatic div_step_t div_step(logic [DIV_DW-1:0] rem, logic nbit,
                                         logic [DIV_DW-1:0] dsr);
    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    div_step_t       s;
    trial = {rem, nbit};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      s.q = 1'b1;
      s.r = diff[DIV_DW-1:0];
    end else begin
      s.q = 1'b0;
      s.r = trial[DIV_DW-1:0];
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/rds_cam.sv =====
// Camera coordinate stage: pipelined restoring divider, column * 2^(F+1) / width,
// one quotient bit per stage, then the 1.0 offset. Depends on rds_pkg.
module rds_cam (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [rds_pkg::COL_W-1:0]        column_i,
  input  logic [rds_pkg::WID_W-1:0]        width_i,
  output logic                             valid_o,
  output logic signed [rds_pkg::CAM_W-1:0] cam_o
);
  import rds_pkg::*;

  logic [DIV_DW-1:0] divisor;
  logic [DIV_NW-1:0] num;

  div_stage_t        stg_q [DIV_NW];
  div_stage_t        stg_d [DIV_NW];
  logic [DIV_NW-1:0] vld_q, vld_d;

  logic                    out_vld_q;
  logic signed [CAM_W-1:0] cam_q, cam_d;
  logic [DIV_NW-1:0]       quo;

  // a zero width counts as one column
  assign divisor = (width_i == '0) ? DIV_DW'(1) : DIV_DW'(width_i);
  assign num     = DIV_NW'({column_i, {(FRAC_BITS + 1){1'b0}}});

  always_comb begin
    div_stage_t src;
    div_step_t  s;
    for (int k = 0; k < DIV_NW; k++) begin
      if (k == 0) begin
        src.rem = '0;
        src.nq  = num;
      end else begin
        src = stg_q[k-1];
      end
      s            = div_step(src.rem, src.nq[DIV_NW-1], divisor);
      stg_d[k].rem = s.r;
      stg_d[k].nq  = {src.nq[DIV_NW-2:0], s.q};
    end
  end

  assign vld_d = {vld_q[DIV_NW-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[DIV_NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
    cam_q <= cam_d;
  end

  assign quo   = stg_q[DIV_NW-1].nq;
  assign cam_d = signed'(CAM_W'(quo[CAM_NUM_W-1:0])) - signed'(CAM_ONE);

  assign valid_o = out_vld_q;
  assign cam_o   = cam_q;

endmodule

// ===== hw/rtl/rds_ray.sv =====
// Ray direction for one axis: plane * cam in one stage, then dir + product / 2^F
// with saturation to the ray range in the next. Depends on rds_pkg.
module rds_ray (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [rds_pkg::CAM_W-1:0] cam_i,
  input  logic signed [rds_pkg::DIR_W-1:0] dir_i,
  input  logic signed [rds_pkg::DIR_W-1:0] plane_i,
  output logic                             valid_o,
  output logic signed [rds_pkg::RAY_W-1:0] ray_o
);
  import rds_pkg::*;

  localparam int PROD_W = DIR_W + CAM_W;
  localparam int SUM_W  = PROD_W - FRAC_BITS + 1;

  localparam logic signed [RAY_W-1:0] RAY_MAX = {1'b0, {(RAY_W - 1){1'b1}}};
  localparam logic signed [RAY_W-1:0] RAY_MIN = {1'b1, {(RAY_W - 1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(RAY_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO  = SUM_W'(RAY_MIN);

  logic                     prod_vld_q, ray_vld_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [SUM_W-1:0]  sum;
  logic signed [RAY_W-1:0]  ray_q, ray_d;

  assign prod_d = PROD_W'(plane_i) * PROD_W'(cam_i);

  // arithmetic shift gives the floor of the scaled product
  assign sum = SUM_W'(dir_i) + SUM_W'(prod_q >>> FRAC_BITS);

  always_comb begin
    if (sum > SAT_HI) begin
      ray_d = RAY_MAX;
    end else if (sum < SAT_LO) begin
      ray_d = RAY_MIN;
    end else begin
      ray_d = sum[RAY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      ray_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= valid_i;
      ray_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    ray_q  <= ray_d;
  end

  assign valid_o = ray_vld_q;
  assign ray_o   = ray_q;

endmodule

// ===== hw/rtl/rds_axis.sv =====
// Per-axis distances: |ray|, pipelined 2^(2F) / |ray| divider, saturation, then
// fraction * delta for the side distance. Depends on rds_pkg.
module rds_axis (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [rds_pkg::RAY_W-1:0]  ray_i,
  input  logic [rds_pkg::FRAC_BITS-1:0]     frac_i,
  output logic                              valid_o,
  output logic signed [rds_pkg::RAY_W-1:0]  ray_o,
  output logic                              neg_o,
  output logic [rds_pkg::DIST_W-1:0]        delta_o,
  output logic [rds_pkg::DIST_W-1:0]        side_o
);
  import rds_pkg::*;

  localparam int DST_W = FRAC_BITS + 1;
  localparam int SP_W  = DST_W + DIST_W;

  localparam logic [DIV_NW-1:0] DELTA_NUM = DIV_NW'(1) << (2 * FRAC_BITS);
  localparam logic [DST_W-1:0]  DST_ONE   = DST_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [DIV_NW-1:0] nq;
    logic [DIV_DW-1:0] rem;
    logic [DIV_DW-1:0] dsr;
    logic [RAY_W-1:0]  ray;
  } axis_stage_t;

  // magnitude stage
  logic             pre_vld_q;
  logic [RAY_W-1:0] mag_q, mag_d;
  logic [RAY_W-1:0] pre_ray_q;

  // divider stages
  axis_stage_t       stg_q [DIV_NW];
  axis_stage_t       stg_d [DIV_NW];
  logic [DIV_NW-1:0] vld_q, vld_d;

  // delta stage
  logic                p1_vld_q;
  logic [DIST_W-1:0]   delta_q, delta_d;
  logic [DST_W-1:0]    dist_q, dist_d;
  logic                zero_q, zero_d;
  logic [RAY_W-1:0]    p1_ray_q;
  logic [DELTA_QW-1:0] quo_ext;
  logic                quo_ovf;
  logic [RAY_W-1:0]    last_ray;

  // side product stage
  logic              p2_vld_q;
  logic [SP_W-1:0]   prod_q, prod_d;
  logic [DIST_W-1:0] p2_delta_q;
  logic              p2_zero_q;
  logic [RAY_W-1:0]  p2_ray_q;

  // output stage
  logic              out_vld_q;
  logic [DIST_W-1:0] side_q, side_d;
  logic [DIST_W-1:0] out_delta_q;
  logic [RAY_W-1:0]  out_ray_q;
  logic [DIST_W:0]   side_wide;

  // the most negative ray maps to 2^(RAY_W-1), still representable unsigned
  assign mag_d = ray_i[RAY_W-1] ? RAY_W'(-ray_i) : RAY_W'(ray_i);

  always_comb begin
    axis_stage_t src;
    div_step_t   s;
    for (int k = 0; k < DIV_NW; k++) begin
      if (k == 0) begin
        src.nq  = DELTA_NUM;
        src.rem = '0;
        src.dsr = DIV_DW'(mag_q);
        src.ray = pre_ray_q;
      end else begin
        src = stg_q[k-1];
      end
      s            = div_step(src.rem, src.nq[DIV_NW-1], src.dsr);
      stg_d[k].nq  = {src.nq[DIV_NW-2:0], s.q};
      stg_d[k].rem = s.r;
      stg_d[k].dsr = src.dsr;
      stg_d[k].ray = src.ray;
    end
  end

  assign vld_d = {vld_q[DIV_NW-2:0], pre_vld_q};

  // a zero ray divides by zero; its delta and side are forced to all ones
  assign last_ray = stg_q[DIV_NW-1].ray;
  assign quo_ext  = DELTA_QW'(stg_q[DIV_NW-1].nq);
  assign quo_ovf  = |quo_ext[DELTA_QW-1:DIST_W];
  assign zero_d   = (last_ray == '0);
  assign delta_d  = (zero_d || quo_ovf) ? '1 : quo_ext[DIST_W-1:0];
  assign dist_d   = last_ray[RAY_W-1] ? {1'b0, frac_i} : DST_ONE - {1'b0, frac_i};

  assign prod_d = SP_W'(dist_q) * SP_W'(delta_q);

  assign side_wide = prod_q[SP_W-1:FRAC_BITS];
  assign side_d    = (p2_zero_q || side_wide[DIST_W]) ? '1 : side_wide[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
      vld_q     <= '0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pre_vld_q <= valid_i;
      vld_q     <= vld_d;
      p1_vld_q  <= vld_q[DIV_NW-1];
      p2_vld_q  <= p1_vld_q;
      out_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    pre_ray_q   <= ray_i;
    stg_q       <= stg_d;
    delta_q     <= delta_d;
    dist_q      <= dist_d;
    zero_q      <= zero_d;
    p1_ray_q    <= last_ray;
    prod_q      <= prod_d;
    p2_delta_q  <= delta_q;
    p2_zero_q   <= zero_q;
    p2_ray_q    <= p1_ray_q;
    side_q      <= side_d;
    out_delta_q <= p2_delta_q;
    out_ray_q   <= p2_ray_q;
  end

  assign valid_o = out_vld_q;
  assign ray_o   = out_ray_q;
  assign neg_o   = out_ray_q[RAY_W-1];
  assign delta_o = out_delta_q;
  assign side_o  = side_q;

endmodule

// ===== hw/rtl/raycast_dda_ray_setup_core.sv =====
// Top level of the DDA ray setup core: configuration registers, camera divider,
// per-axis ray and distance pipelines. Depends on rds_pkg, rds_cam, rds_ray, rds_axis.
//
// One screen column is taken per clock cycle, every cycle: busy_o never rises, so
// start_i may be held high continuously. Each column yields exactly one result, shown
// for one cycle with done_o; results leave in the order the columns came in and cannot
// be held off. The pipeline is built from two chains of restoring divider stages, one
// quotient bit per stage: column*2^(F+1)/width for the camera coordinate and
// 2^(2F)/|ray| for the delta distances. Configuration writes take effect at once and
// must only be made while no column is in flight.
module raycast_dda_ray_setup_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rds_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [rds_pkg::COL_W-1:0]           column_i,
  output logic                                done_o,
  output logic signed [rds_pkg::RAY_W-1:0]    ray_x_o,
  output logic signed [rds_pkg::RAY_W-1:0]    ray_y_o,
  output logic [rds_pkg::MAP_BITS-1:0]        map_x_o,
  output logic [rds_pkg::MAP_BITS-1:0]        map_y_o,
  output logic                                step_x_negative_o,
  output logic                                step_y_negative_o,
  output logic [rds_pkg::DIST_W-1:0]          delta_x_o,
  output logic [rds_pkg::DIST_W-1:0]          delta_y_o,
  output logic [rds_pkg::DIST_W-1:0]          side_x_o,
  output logic [rds_pkg::DIST_W-1:0]          side_y_o
);
  import rds_pkg::*;

  logic [POS_W-1:0]        pos_x_q, pos_y_q;
  logic signed [DIR_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [WID_W-1:0]        width_q;

  logic                    in_xfer;
  logic                    cam_vld;
  logic signed [CAM_W-1:0] cam;
  logic                    ray_x_vld, ray_y_vld;
  logic signed [RAY_W-1:0] ray_x, ray_y;
  logic                    x_done, y_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      dir_x_q   <= DIR_X_RST;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= PLANE_Y_RST;
      width_q   <= WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POS_X:   pos_x_q   <= cfg_wdata_i[POS_W-1:0];
        REG_POS_Y:   pos_y_q   <= cfg_wdata_i[POS_W-1:0];
        REG_DIR_X:   dir_x_q   <= cfg_wdata_i[DIR_W-1:0];
        REG_DIR_Y:   dir_y_q   <= cfg_wdata_i[DIR_W-1:0];
        REG_PLANE_X: plane_x_q <= cfg_wdata_i[DIR_W-1:0];
        REG_PLANE_Y: plane_y_q <= cfg_wdata_i[DIR_W-1:0];
        REG_WIDTH:   width_q   <= cfg_wdata_i[WID_W-1:0];
        default: ;
      endcase
    end
  end

  // fully pipelined, no backpressure from the result side
  assign busy_o  = 1'b0;
  assign in_xfer = start_i && !busy_o;

  rds_cam u_cam (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_xfer),
    .column_i (column_i),
    .width_i  (width_q),
    .valid_o  (cam_vld),
    .cam_o    (cam)
  );

  rds_ray u_ray_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cam_vld),
    .cam_i   (cam),
    .dir_i   (dir_x_q),
    .plane_i (plane_x_q),
    .valid_o (ray_x_vld),
    .ray_o   (ray_x)
  );

  rds_ray u_ray_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cam_vld),
    .cam_i   (cam),
    .dir_i   (dir_y_q),
    .plane_i (plane_y_q),
    .valid_o (ray_y_vld),
    .ray_o   (ray_y)
  );

  rds_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ray_x_vld),
    .ray_i   (ray_x),
    .frac_i  (pos_x_q[FRAC_BITS-1:0]),
    .valid_o (x_done),
    .ray_o   (ray_x_o),
    .neg_o   (step_x_negative_o),
    .delta_o (delta_x_o),
    .side_o  (side_x_o)
  );

  rds_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ray_y_vld),
    .ray_i   (ray_y),
    .frac_i  (pos_y_q[FRAC_BITS-1:0]),
    .valid_o (y_done),
    .ray_o   (ray_y_o),
    .neg_o   (step_y_negative_o),
    .delta_o (delta_y_o),
    .side_o  (side_y_o)
  );

  assign done_o  = x_done;
  assign map_x_o = pos_x_q[POS_W-1:FRAC_BITS];
  assign map_y_o = pos_y_q[POS_W-1:FRAC_BITS];

  // both axis pipelines must stay in lockstep
  a_axis_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_done == y_done)
    else $error("x and y axis pipelines out of step");

  a_zero_ray_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ray_x_o == '0) |-> (delta_x_o == '1 && side_x_o == '1))
    else $error("zero x ray without saturated distances");

  a_delta_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (delta_x_o != '0 && delta_y_o != '0))
    else $error("delta distance of zero on a valid result");

endmodule
